// File: sv/crcfb_pkg.sv
// Shared types and codes for the CRC forward/backward patch engine.
// No dependencies; imported by the channel interfaces, the top level and the testbench.
`default_nettype none

package crcfb_pkg;

    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_START_FWD = 3'd0,
        FN_FWD_BYTE  = 3'd1,
        FN_START_BWD = 3'd2,
        FN_BWD_BYTE  = 3'd3,
        FN_FINISH    = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH = 2'd0,
        CFG_POLY  = 2'd1,
        CFG_INIT  = 2'd2,
        CFG_OXOR  = 2'd3
    } t_cfg_idx;

    // state memory entries
    localparam logic ENT_FWD = 1'b0;
    localparam logic ENT_BWD = 1'b1;

    localparam logic [2:0]        RST_WIDTH = 3'd4;
    localparam logic [WORD_W-1:0] RST_POLY  = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] RST_INIT  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] RST_OXOR  = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: sv/crcfb_in_if.sv
// Input item channel: valid/ready handshake with command payload.
// Depends on crcfb_pkg.
`default_nettype none

interface crcfb_in_if
    import crcfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] target_value;

    modport source (output valid, output func, output data_byte, output target_value,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input target_value,
                    output ready);
endinterface

`default_nettype wire

// File: sv/crcfb_out_if.sv
// Result item channel: valid/ready handshake with checksum and patch payload.
// Depends on crcfb_pkg.
`default_nettype none

interface crcfb_out_if
    import crcfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] checksum_now;
    logic [WORD_W-1:0] backward_now;
    logic [WORD_W-1:0] patch_word;
    logic              patch_valid;

    modport source (output valid, output checksum_now, output backward_now,
                    output patch_word, output patch_valid, input ready);
    modport sink   (input valid, input checksum_now, input backward_now,
                    input patch_word, input patch_valid, output ready);
endinterface

`default_nettype wire

// File: sv/crc_forward_backward_patch.sv
// Top level of the reflected CRC forward/backward patch engine.
// Depends on crcfb_pkg, crcfb_in_if, crcfb_out_if, crcfb_ram.
//
// Usage:
//   i_in carries commands (func, data_byte, target_value); o_out returns one
//   result item per command: checksum_now, backward_now, patch_word and
//   patch_valid, all taken after the command's update.
//   Configuration (width, polynomial, init and final XOR) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
//   Forward and backward CRC registers live in a two-entry state RAM with a
//   registered read; the item's stage reads both entries, updates and
//   writes back at most one, and a bypass register forwards the last write
//   to the next item. Per-byte table entries are XORs of eight basis words
//   that are derived from the polynomial and registered in the cycle after
//   a config write. Throughput: one item per cycle while the receiver keeps
//   up. An accepted item passes the state stage and then the output register.
//   Reset clears config to width 4, poly 0x04C11DB7, init/final XOR all ones,
//   forward register all ones, backward register zero, and empties the pipe.
//   When the receiver stalls, the output register holds and one more item
//   waits in the state stage; i_in.ready then drops.
`default_nettype none

module crc_forward_backward_patch
    import crcfb_pkg::*;
#(
    parameter int MAX_BYTES = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    crcfb_in_if.sink                  i_in,
    crcfb_out_if.source               o_out
);
    localparam int SW  = 8 * MAX_BYTES;
    localparam int SHW = $clog2(SW);

    typedef logic [SW-1:0] t_basis [8];

    // config
    logic [2:0]        r_width;
    logic [WORD_W-1:0] r_poly;
    logic [WORD_W-1:0] r_init;
    logic [WORD_W-1:0] r_oxor;

    // basis words
    t_basis r_fb;
    t_basis r_ib;
    t_basis n_fb;
    t_basis n_ib;

    // state stage
    logic              r_s1_vld;
    logic [FUNC_W-1:0] r_s1_func;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [WORD_W-1:0] r_s1_tgt;

    logic [1:0]    r_ent_vld;
    logic          r_byp_vld;
    logic          r_byp_addr;
    logic [SW-1:0] r_byp_data;

    logic [SW-1:0] rd_fwd;
    logic [SW-1:0] rd_bwd;

    // output register
    logic              r_out_vld;
    logic [WORD_W-1:0] r_cks;
    logic [WORD_W-1:0] r_bwd;
    logic [WORD_W-1:0] r_patch;
    logic              r_pv;

    logic [2:0]     eff_n;
    logic [SW-1:0]  mask;
    logic [5:0]     sh_top;
    logic [5:0]     tpos6;
    logic [SHW-1:0] tpos;
    logic [SW-1:0]  p_rev;

    logic          adv;
    logic          take;
    logic [SW-1:0] cur_f;
    logic [SW-1:0] cur_b;
    logic [SW-1:0] n_f;
    logic [SW-1:0] n_b;
    logic [SW-1:0] patch;
    logic          pv;
    logic          we;
    logic          waddr;
    logic [SW-1:0] wdata;

    function automatic logic [SW-1:0] f_mask(input logic [2:0] n);
        logic [SW-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_BYTES; k++) begin
            if (k < int'(n)) begin
                m[8*k +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [SW-1:0] f_lut(input t_basis bs, input logic [7:0] idx);
        logic [SW-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (idx[i]) begin
                r = r ^ bs[i];
            end
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] f_prev(input logic [SW-1:0] rg, input logic [7:0] b,
                                             input logic [5:0] sh, input logic [SW-1:0] m,
                                             input t_basis ib);
        logic [SW-1:0] top;
        top = rg >> sh;
        return ((rg << 8) ^ f_lut(ib, top[7:0]) ^ SW'(b)) & m;
    endfunction

    // effective width and derived shifts
    always_comb begin
        priority if (r_width == 3'd0) begin
            eff_n = 3'd1;
        end else if (r_width > 3'(MAX_BYTES)) begin
            eff_n = 3'(MAX_BYTES);
        end else begin
            eff_n = r_width;
        end
        mask   = f_mask(eff_n);
        sh_top = {eff_n - 3'd1, 3'b000};
        tpos6  = {eff_n, 3'b000} - 6'd1;
        tpos   = tpos6[SHW-1:0];
    end

    // polynomial reversal and table basis
    always_comb begin
        logic [SW-1:0] pm;
        logic [SW-1:0] pr;
        logic [SW-1:0] c;
        pm = r_poly[SW-1:0] & mask;
        for (int i = 0; i < SW; i++) begin
            pr[SW-1-i] = pm[i];
        end
        p_rev = pr >> (6'(SW) - {eff_n, 3'b000});
        for (int i = 0; i < 8; i++) begin
            c = SW'(1) << i;
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ p_rev) : (c >> 1);
            end
            n_fb[i] = c & mask;
            c = (SW'(1) << i) << sh_top;
            for (int k = 0; k < 8; k++) begin
                c = c[tpos] ? ((c << 1) ^ (p_rev << 1) ^ SW'(1)) : (c << 1);
            end
            n_ib[i] = c & mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fb <= n_fb;
        r_ib <= n_ib;
    end

    // state RAM
    crcfb_ram #(
        .W     (SW),
        .DEPTH (2)
    ) u_state (
        .i_clk     (i_clk),
        .i_we      (we && adv),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (ENT_FWD),
        .o_rdata_a (rd_fwd),
        .i_raddr_b (ENT_BWD),
        .o_rdata_b (rd_bwd)
    );

    assign adv  = r_s1_vld && (!r_out_vld || o_out.ready);
    assign take = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (!r_s1_vld || adv);

    // read of both state entries, update and write-back of at most one
    always_comb begin
        logic [SW-1:0] fm;
        logic [SW-1:0] bm;
        logic [SW-1:0] p;
        priority if (r_byp_vld && r_byp_addr == ENT_FWD) begin
            cur_f = r_byp_data;
        end else if (r_ent_vld[ENT_FWD]) begin
            cur_f = rd_fwd;
        end else begin
            cur_f = '1;
        end
        priority if (r_byp_vld && r_byp_addr == ENT_BWD) begin
            cur_b = r_byp_data;
        end else if (r_ent_vld[ENT_BWD]) begin
            cur_b = rd_bwd;
        end else begin
            cur_b = '0;
        end
        fm    = cur_f & mask;
        bm    = cur_b & mask;
        n_f   = cur_f;
        n_b   = cur_b;
        patch = '0;
        pv    = 1'b0;
        we    = 1'b0;
        waddr = ENT_FWD;
        p     = bm;
        unique case (t_func'(r_s1_func))
            FN_START_FWD: begin
                n_f = r_init[SW-1:0] & mask;
                we  = 1'b1;
            end
            FN_FWD_BYTE: begin
                n_f = ((fm >> 8) ^ f_lut(r_fb, fm[7:0] ^ r_s1_byte)) & mask;
                we  = 1'b1;
            end
            FN_START_BWD: begin
                n_b   = (r_s1_tgt[SW-1:0] ^ r_oxor[SW-1:0]) & mask;
                we    = 1'b1;
                waddr = ENT_BWD;
            end
            FN_BWD_BYTE: begin
                n_b   = f_prev(bm, r_s1_byte, sh_top, mask, r_ib);
                we    = 1'b1;
                waddr = ENT_BWD;
            end
            FN_FINISH: begin
                for (int k = MAX_BYTES - 1; k >= 0; k--) begin
                    if (k < int'(eff_n)) begin
                        p = f_prev(p, fm[8*k +: 8], sh_top, mask, r_ib);
                    end
                end
                patch = p;
                pv    = 1'b1;
            end
            default: begin
            end
        endcase
        wdata = (waddr == ENT_FWD) ? n_f : n_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_poly    <= RST_POLY;
            r_init    <= RST_INIT;
            r_oxor    <= RST_OXOR;
            r_s1_vld  <= 1'b0;
            r_ent_vld <= 2'b00;
            r_byp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH: r_width <= i_cfg_data[2:0];
                    CFG_POLY:  r_poly  <= i_cfg_data;
                    CFG_INIT:  r_init  <= i_cfg_data;
                    CFG_OXOR:  r_oxor  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (take) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            r_byp_vld <= adv && we;
            if (adv && we) begin
                r_ent_vld[waddr] <= 1'b1;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_func <= i_in.func;
            r_s1_byte <= i_in.data_byte;
            r_s1_tgt  <= i_in.target_value;
        end
        r_byp_addr <= waddr;
        r_byp_data <= wdata;
        if (adv) begin
            r_cks   <= WORD_W'((n_f ^ r_oxor[SW-1:0]) & mask);
            r_bwd   <= WORD_W'(n_b & mask);
            r_patch <= WORD_W'(patch & mask);
            r_pv    <= pv;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.checksum_now = r_cks;
    assign o_out.backward_now = r_bwd;
    assign o_out.patch_word   = r_patch;
    assign o_out.patch_valid  = r_pv;

endmodule

`default_nettype wire

// File: sv/crcfb_ram.sv
// Generic RAM: one write port, two registered read ports (read-old-data).
// No dependencies.
`default_nettype none

module crcfb_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [W-1:0]             o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [W-1:0]             o_rdata_b
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for crc_forward_backward_patch: drives command items, predicts each result
// with a bit-level CRC forward/backward model, and checks every result item in order.
// Depends on crcfb_pkg, crcfb_in_if, crcfb_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top
    import crcfb_pkg::*;
();

    localparam int MAX_BYTES   = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAD   = 4;
    localparam int LONG_HOLD   = 200;

    typedef struct packed {
        logic [WORD_W-1:0] checksum_now;
        logic [WORD_W-1:0] backward_now;
        logic [WORD_W-1:0] patch_word;
        logic              patch_valid;
    } t_crc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0] i_cfg_data;
    logic sink_ready = 1'b0;

    crcfb_in_if  in_ch ();
    crcfb_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    crc_forward_backward_patch #(.MAX_BYTES(MAX_BYTES)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // model state and configuration
    logic [2:0]        cfg_width = RST_WIDTH;
    logic [WORD_W-1:0] cfg_poly  = RST_POLY;
    logic [WORD_W-1:0] cfg_init  = RST_INIT;
    logic [WORD_W-1:0] cfg_oxor  = RST_OXOR;
    logic [WORD_W-1:0] fwd_crc   = RST_INIT;
    logic [WORD_W-1:0] bwd_crc   = '0;

    t_crc_result due_results[$];
    int  fail_count  = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    bit  no_gaps     = 1'b0;
    int  hold_asked  = 0;
    int  hold_done   = 0;
    int  sink_stall  = 0;

    function automatic int unsigned crc_bytes();
        int unsigned n;
        n = 32'(cfg_width);
        if (n < 1) n = 1;
        if (n > MAX_BYTES) n = MAX_BYTES;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] crc_mask();
        int unsigned n;
        n = crc_bytes();
        if (n >= 4) return '1;
        return (32'h1 << (8 * n)) - 32'h1;
    endfunction

    function automatic logic [WORD_W-1:0] poly_reflected();
        logic [WORD_W-1:0] r;
        int unsigned bits;
        bits = 8 * crc_bytes();
        r = '0;
        for (int i = 0; i < bits; i++)
            if (cfg_poly[i]) r[bits-1-i] = 1'b1;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] fwd_table(input logic [7:0] idx);
        logic [WORD_W-1:0] p, c;
        p = poly_reflected();
        c = {24'h0, idx};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
        return c & crc_mask();
    endfunction

    function automatic logic [WORD_W-1:0] inv_table(input logic [7:0] idx);
        logic [WORD_W-1:0] p, c, top;
        int unsigned bits;
        bits = 8 * crc_bytes();
        p = poly_reflected();
        top = 32'h1 << (bits - 1);
        c = {24'h0, idx} << (bits - 8);
        for (int k = 0; k < 8; k++)
            c = ((c & top) != 0) ? (((c ^ p) << 1) | 32'h1) : (c << 1);
        return c & crc_mask();
    endfunction

    function automatic logic [WORD_W-1:0] crc_advance(input logic [WORD_W-1:0] r,
                                                     input logic [7:0] b);
        logic [WORD_W-1:0] m, x;
        m = crc_mask();
        r = r & m;
        x = r ^ {24'h0, b};
        return ((r >> 8) ^ fwd_table(x[7:0])) & m;
    endfunction

    function automatic logic [WORD_W-1:0] crc_retreat(input logic [WORD_W-1:0] r,
                                                     input logic [7:0] b);
        logic [WORD_W-1:0] m, hi;
        int unsigned bits;
        m = crc_mask();
        bits = 8 * crc_bytes();
        r = r & m;
        hi = r >> (bits - 8);
        return ((r << 8) ^ inv_table(hi[7:0]) ^ {24'h0, b}) & m;
    endfunction

    function automatic t_crc_result forge_step(input logic [FUNC_W-1:0] f,
                                               input logic [7:0] b,
                                               input logic [WORD_W-1:0] target);
        t_crc_result res;
        logic [WORD_W-1:0] m, patch, fr, sh;
        int n;
        m = crc_mask();
        patch = '0;
        res.patch_valid = 1'b0;
        case (f)
            FN_START_FWD: fwd_crc = cfg_init & m;
            FN_FWD_BYTE:  fwd_crc = crc_advance(fwd_crc, b);
            FN_START_BWD: bwd_crc = (target ^ cfg_oxor) & m;
            FN_BWD_BYTE:  bwd_crc = crc_retreat(bwd_crc, b);
            FN_FINISH: begin
                n = crc_bytes();
                fr = fwd_crc & m;
                patch = bwd_crc & m;
                for (int j = n; j > 0; j--) begin
                    sh = fr >> (8 * (j - 1));
                    patch = crc_retreat(patch, sh[7:0]);
                end
                res.patch_valid = 1'b1;
            end
            default: ;
        endcase
        res.checksum_now = (fwd_crc ^ cfg_oxor) & m;
        res.backward_now = bwd_crc & m;
        res.patch_word   = patch & m;
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [7:0] b,
                            input logic [WORD_W-1:0] target);
        int gap;
        gap = (!no_gaps && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= f;
        in_ch.data_byte    <= b;
        in_ch.target_value <= target;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        due_results.push_back(forge_step(f, b, target));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [WORD_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH: cfg_width = value[2:0];
            CFG_POLY:  cfg_poly  = value;
            CFG_INIT:  cfg_init  = value;
            CFG_OXOR:  cfg_oxor  = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] w, input logic [WORD_W-1:0] poly,
                              input logic [WORD_W-1:0] init, input logic [WORD_W-1:0] oxor);
        wait_drained();
        write_reg(CFG_WIDTH, {29'h0, w});
        write_reg(CFG_POLY, poly);
        write_reg(CFG_INIT, init);
        write_reg(CFG_OXOR, oxor);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic patch_session(input int nf, input int nb);
        send_cmd(FN_START_FWD, 8'($urandom_range(0, 255)), $urandom());
        repeat (nf) send_cmd(FN_FWD_BYTE, 8'($urandom_range(0, 255)), $urandom());
        send_cmd(FN_START_BWD, 8'($urandom_range(0, 255)), $urandom());
        repeat (nb) send_cmd(FN_BWD_BYTE, 8'($urandom_range(0, 255)), $urandom());
        send_cmd(FN_FINISH, 8'($urandom_range(0, 255)), $urandom());
    endtask

    task automatic test_reset_defaults();
        send_cmd(FN_FINISH, 8'h00, 32'h0);
        send_cmd(3'd5, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(3'd6, 8'h00, 32'h0);
        send_cmd(3'd7, 8'h5A, 32'h1234_5678);
        send_cmd(FN_FWD_BYTE, 8'h00, 32'h0);
        send_cmd(FN_FWD_BYTE, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(FN_START_BWD, 8'h00, 32'h0);
        send_cmd(FN_BWD_BYTE, 8'hFF, 32'h0);
        send_cmd(FN_FINISH, 8'h00, 32'h0);
        send_cmd(FN_START_BWD, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(FN_BWD_BYTE, 8'h00, 32'hFFFF_FFFF);
        send_cmd(FN_FINISH, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(FN_START_FWD, 8'h00, 32'h0);
        send_cmd(FN_FINISH, 8'h00, 32'h0);
    endtask

    // width 0 acts as one byte, widths above MAX_BYTES clamp
    task automatic test_width_extremes();
        set_config(3'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        patch_session(1, 1);
        set_config(3'd7, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        patch_session(1, 1);
        set_config(3'd1, 32'h0000_0007, 32'hFFFF_FF5A, 32'h0000_00A5);
        patch_session(1, 1);
    endtask

    task automatic test_random_phases();
        int phase_end;
        for (int ph = 0; ph < 12; ph++) begin
            set_config(3'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word());
            no_gaps = (ph % 4 == 3);
            phase_end = items_sent + 100;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 75)
                    patch_session($urandom_range(0, 8), $urandom_range(0, 8));
                else
                    send_cmd(FUNC_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             $urandom());
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        set_config(3'd4, RST_POLY, RST_INIT, RST_OXOR);
        no_gaps = 1'b1;
        hold_asked++;
        repeat (6) patch_session(4, 4);
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done  <= hold_asked;
            sink_stall <= LONG_HOLD;
            sink_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            sink_ready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
            sink_stall <= gap_len() - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_crc_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_results.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                exp_res = due_results.pop_front();
                if (out_ch.checksum_now !== exp_res.checksum_now) begin
                    $error("checksum_now: expected %h, got %h",
                           exp_res.checksum_now, out_ch.checksum_now);
                    fail_count++;
                end
                if (out_ch.backward_now !== exp_res.backward_now) begin
                    $error("backward_now: expected %h, got %h",
                           exp_res.backward_now, out_ch.backward_now);
                    fail_count++;
                end
                if (out_ch.patch_word !== exp_res.patch_word) begin
                    $error("patch_word: expected %h, got %h",
                           exp_res.patch_word, out_ch.patch_word);
                    fail_count++;
                end
                if (out_ch.patch_valid !== exp_res.patch_valid) begin
                    $error("patch_valid: expected %b, got %b",
                           exp_res.patch_valid, out_ch.patch_valid);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_WIDTH;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= FN_START_FWD;
        in_ch.data_byte    <= '0;
        in_ch.target_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_width_extremes();
        test_backpressure();
        test_random_phases();

        wait_drained();
        if (fail_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
